/* rtl/core/modbus_rtu_master_frame_engine_macros.svh */
// Assertion macros for the Modbus RTU master frame engine.
`ifndef MODBUS_RTU_MASTER_FRAME_ENGINE_MACROS_SVH
`define MODBUS_RTU_MASTER_FRAME_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MRM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MRM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MRM_ASSERT_IMP(label, clk, rst, ante, cons)
`define MRM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/mrm_pkg.sv */
// Shared types, codes and the CRC step function of the Modbus RTU master.
package mrm_pkg;
   localparam int RespBytesDefault = 64;
   localparam int MaxRegsDefault = 29;
   localparam int FailLimitDefault = 5;

   localparam logic [1:0] ACT_READ = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_BYTE = 2'd2;
   localparam logic [1:0] ACT_END = 2'd3;

   localparam logic [1:0] KIND_TX = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_TIMEOUT = 3'd1;
   localparam logic [2:0] ST_CRC = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_SIZE = 3'd4;

   localparam logic [7:0] FC_READ = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h06;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [15:0] reg_word;
      logic [2:0]  status;
      logic        link_ok;
      logic        last;
   } rsp_type;

   // One byte of CRC-16, bit by bit (eight narrow dependent steps).
   function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction
endpackage

/* rtl/core/mrm_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module mrm_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/modbus_rtu_master_frame_engine.sv */
// Modbus RTU master: request framing, response buffering, checking, link health.
// An accepted request offers its frame bytes one a cycle while rsp_tready holds;
// the next request is taken once the last byte has left.
// A frame-completing byte starts a walk of the receive RAM, one byte a cycle; the header check,
// words and status follow; other bytes go back to back.
// Reset (synchronous, active high) clears control state; the RAM keeps its contents.
`include "modbus_rtu_master_frame_engine_macros.svh"
module modbus_rtu_master_frame_engine #(
   parameter int RespBytes = mrm_pkg::RespBytesDefault,
   parameter int MaxRegs = mrm_pkg::MaxRegsDefault,
   parameter int FailLimit = mrm_pkg::FailLimitDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: reg_address[15:0], word_value[31:16], rx_byte[39:32]
   input  logic [39:0] req_tdata,
   // tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: tx_byte[7:0], reg_word[23:8], status[26:24], link_ok[27], zero fill
   output logic [31:0] rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   localparam int AW = $clog2(RespBytes);
   localparam int CW = $clog2(RespBytes + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TX = 4'd1;
   localparam logic [3:0] S_CRC = 4'd2;    // walk RAM bytes into the CRC
   localparam logic [3:0] S_CHK = 4'd3;    // compare CRC, header fields
   localparam logic [3:0] S_WHI = 4'd4;    // read word high byte
   localparam logic [3:0] S_WLO = 4'd5;    // read word low byte, emit
   localparam logic [3:0] S_STAT = 4'd6;

   // header walk steps inside S_WHI
   localparam logic [3:0] R_SLAVE = 4'd0;
   localparam logic [3:0] R_FUNC = 4'd1;
   localparam logic [3:0] R_COUNT = 4'd2;
   localparam logic [3:0] R_WORDS = 4'd3;

   logic [3:0]  state_ff, state_in, ret_ff, ret_in;
   logic [7:0]  slave_ff, slave_in, pslave_ff, pslave_in;
   logic [CW-1:0] rx_cnt_ff, rx_cnt_in, exp_ff, exp_in, ptr_ff, ptr_in, lim_ff, lim_in;
   logic        is_wr_ff, is_wr_in, active_ff, active_in;
   logic [6:0]  pcount_ff, pcount_in, widx_ff, widx_in;
   logic [3:0]  fail_ff, fail_in;
   logic        link_ff, link_in;
   logic [15:0] crc_ff, crc_in, rcrc_ff, rcrc_in;
   logic [7:0]  frame_ff [8];
   logic [7:0]  frame_in [8];
   logic [7:0]  b1_ff, b1_in, whi_ff, whi_in;
   logic [2:0]  st_ff, st_in, txi_ff, txi_in;
   logic        endchk_ff, endchk_in, rd_pend_ff, rd_pend_in;
   logic        ov_ff, ov_in;
   mrm_pkg::rsp_type out_ff, out_in;
   logic        ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [7:0]  ram_rd;

   mrm_ram #(.Width(8), .Depth(RespBytes)) u_rxbuf (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(req_tdata[39:32]),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tuser = out_ff.kind;
   assign rsp_tlast = out_ff.last;
   assign rsp_tdata = {4'd0, out_ff.link_ok, out_ff.status, out_ff.reg_word, out_ff.tx_byte};

   always_comb begin
      logic [16:0] need;
      logic [2:0]  s;
      logic [3:0]  f;
      logic        l;
      state_in = state_ff; ret_in = ret_ff; slave_in = slave_ff; pslave_in = pslave_ff;
      rx_cnt_in = rx_cnt_ff; exp_in = exp_ff; ptr_in = ptr_ff; lim_in = lim_ff;
      is_wr_in = is_wr_ff; active_in = active_ff; pcount_in = pcount_ff;
      widx_in = widx_ff; fail_in = fail_ff; link_in = link_ff; crc_in = crc_ff;
      rcrc_in = rcrc_ff; frame_in = frame_ff; b1_in = b1_ff; whi_in = whi_ff;
      st_in = st_ff; txi_in = txi_ff; endchk_in = endchk_ff; rd_pend_in = rd_pend_ff;
      ov_in = ov_ff; out_in = out_ff;
      ram_we = 1'b0; ram_wa = rx_cnt_ff[AW-1:0]; ram_ra = ptr_ff[AW-1:0];
      need = 17'd5 + {req_tdata[31:16], 1'b0};
      s = st_ff; f = fail_ff; l = link_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      if (csr_valid) slave_in = csr_data;
      // status accounting used by S_STAT
      if (st_ff == mrm_pkg::ST_OK) begin
         f = 4'd0; l = 1'b1;
      end else if (fail_ff < 4'(FailLimit)) begin
         f = fail_ff + 4'd1;
         if (f == 4'(FailLimit)) l = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_tuser)
                  mrm_pkg::ACT_READ, mrm_pkg::ACT_WRITE: begin
                     active_in = 1'b0; rx_cnt_in = '0;
                     if (req_tuser == mrm_pkg::ACT_READ && (req_tdata[31:16] > 16'(MaxRegs)
                         || need > 17'(RespBytes))) begin
                        st_in = mrm_pkg::ST_SIZE; state_in = S_STAT;
                     end else begin
                        frame_in[0] = slave_ff;
                        frame_in[1] = (req_tuser == mrm_pkg::ACT_READ) ?
                                      mrm_pkg::FC_READ : mrm_pkg::FC_WRITE;
                        frame_in[2] = req_tdata[15:8]; frame_in[3] = req_tdata[7:0];
                        frame_in[4] = req_tdata[31:24]; frame_in[5] = req_tdata[23:16];
                        pslave_in = slave_ff;
                        is_wr_in = (req_tuser == mrm_pkg::ACT_WRITE);
                        pcount_in = is_wr_in ? 7'd0 : req_tdata[22:16];
                        exp_in = is_wr_in ? CW'(8) : CW'(need);
                        crc_in = mrm_pkg::CRC_INIT;
                        active_in = 1'b1; txi_in = 3'd0; state_in = S_TX;
                     end
                  end
                  mrm_pkg::ACT_BYTE: begin
                     if (active_ff) begin
                        if (rx_cnt_ff < exp_ff) begin
                           ram_we = 1'b1; rx_cnt_in = rx_cnt_ff + CW'(1);
                        end
                        if (rx_cnt_in >= exp_ff) begin
                           active_in = 1'b0; rx_cnt_in = '0;
                           lim_in = exp_ff - CW'(2); endchk_in = 1'b0;
                           ptr_in = '0; crc_in = mrm_pkg::CRC_INIT;
                           rd_pend_in = 1'b0; state_in = S_CRC;
                        end
                     end
                  end
                  default: begin
                     if (active_ff) begin
                        active_in = 1'b0; rx_cnt_in = '0;
                        if (rx_cnt_ff >= CW'(5)) begin
                           lim_in = CW'(3); endchk_in = 1'b1; ptr_in = '0;
                           crc_in = mrm_pkg::CRC_INIT; rd_pend_in = 1'b0;
                           state_in = S_CRC;
                        end else begin
                           st_in = mrm_pkg::ST_TIMEOUT; state_in = S_STAT;
                        end
                     end
                  end
               endcase
            end
         end
         S_TX: begin
            // fold each header byte into the CRC as it leaves
            if (!ov_in) begin
               ov_in = 1'b1;
               out_in = '0;
               out_in.kind = mrm_pkg::KIND_TX;
               out_in.tx_byte = (txi_ff < 3'd6) ? frame_ff[txi_ff] :
                                (txi_ff == 3'd6) ? crc_ff[7:0] : crc_ff[15:8];
               if (txi_ff < 3'd6) crc_in = mrm_pkg::crc_byte(crc_ff, frame_ff[txi_ff]);
               out_in.last = (txi_ff == 3'd7);
               txi_in = txi_ff + 3'd1;
               if (txi_ff == 3'd7) state_in = S_IDLE;
            end
         end
         S_CRC: begin
            // pipeline: issue read at ptr, fold the byte returned in the next cycle
            rd_pend_in = 1'b1;
            if (rd_pend_ff) begin
               if (ptr_ff <= lim_ff) crc_in = mrm_pkg::crc_byte(crc_ff, ram_rd);
               else if (ptr_ff == lim_ff + CW'(1)) rcrc_in[7:0] = ram_rd;
               else rcrc_in[15:8] = ram_rd;
               if (ptr_ff == CW'(2)) b1_in = ram_rd;
            end
            if (ptr_ff == lim_ff + CW'(2)) state_in = S_CHK;
            else ptr_in = ptr_ff + CW'(1);
         end
         S_CHK: begin
            if (endchk_ff) begin
               st_in = (b1_ff[7] && crc_ff == rcrc_ff) ? mrm_pkg::ST_INVALID :
                       mrm_pkg::ST_TIMEOUT;
               state_in = S_STAT;
            end else if (crc_ff != rcrc_ff) begin
               st_in = mrm_pkg::ST_CRC; state_in = S_STAT;
            end else if (frame_ff[0] != pslave_ff) begin
               st_in = mrm_pkg::ST_INVALID; state_in = S_STAT;
            end else begin
               // re-read byte 0 and byte 2 via the word walk: header check
               ptr_in = '0; widx_in = '0; rd_pend_in = 1'b0;
               st_in = mrm_pkg::ST_OK; state_in = S_WHI; ret_in = R_SLAVE;
            end
         end
         S_WHI: begin
            // ret_ff: header slave, fc, byte count, then words
            case (ret_ff)
               R_SLAVE: begin
                  ram_ra = '0; ret_in = R_FUNC;
               end
               R_FUNC: begin
                  ram_ra = AW'(2);
                  if (ram_rd != pslave_ff || (b1_ff & 8'h7F) != frame_ff[1]
                      || b1_ff[7]) begin
                     st_in = mrm_pkg::ST_INVALID; state_in = S_STAT;
                  end
                  ret_in = R_COUNT;
               end
               R_COUNT: begin
                  ram_ra = AW'(3);
                  if (!is_wr_ff && ram_rd != {pcount_ff, 1'b0}) begin
                     st_in = mrm_pkg::ST_INVALID; state_in = S_STAT;
                  end else if (is_wr_ff || pcount_ff == 7'd0) begin
                     state_in = S_STAT;
                  end
                  ptr_in = CW'(3); ret_in = R_WORDS;
               end
               default: begin
                  ram_ra = AW'(ptr_ff + CW'(1));
                  whi_in = ram_rd; state_in = S_WLO;
               end
            endcase
         end
         S_WLO: begin
            ram_ra = AW'(ptr_ff + CW'(2));
            if (!ov_in) begin
               ov_in = 1'b1; out_in = '0;
               out_in.kind = mrm_pkg::KIND_WORD;
               out_in.reg_word = {whi_ff, ram_rd};
               widx_in = widx_ff + 7'd1; ptr_in = ptr_ff + CW'(2);
               state_in = (widx_in == pcount_ff) ? S_STAT : S_WHI;
            end else begin
               ram_ra = AW'(ptr_ff + CW'(1));
            end
         end
         S_STAT: begin
            if (!ov_in) begin
               ov_in = 1'b1; out_in = '0;
               out_in.kind = mrm_pkg::KIND_STATUS; out_in.status = s;
               out_in.link_ok = l; out_in.last = 1'b1;
               fail_in = f; link_in = l; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // frame_ff[0] doubles as slave shadow only for the transmit frame
      if (state_ff == S_CRC && rd_pend_ff && ptr_ff == CW'(1)) frame_in[0] = frame_ff[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; slave_ff <= 8'd1; active_ff <= 1'b0; rx_cnt_ff <= '0;
         fail_ff <= '0; link_ff <= 1'b0; ov_ff <= 1'b0; exp_ff <= '0;
         is_wr_ff <= 1'b0; pcount_ff <= '0; pslave_ff <= '0;
      end else begin
         state_ff <= state_in; slave_ff <= slave_in; active_ff <= active_in;
         rx_cnt_ff <= rx_cnt_in; fail_ff <= fail_in; link_ff <= link_in; ov_ff <= ov_in;
         exp_ff <= exp_in; is_wr_ff <= is_wr_in; pcount_ff <= pcount_in;
         pslave_ff <= pslave_in;
      end
      ret_ff <= ret_in; ptr_ff <= ptr_in; lim_ff <= lim_in; widx_ff <= widx_in;
      crc_ff <= crc_in; rcrc_ff <= rcrc_in; frame_ff <= frame_in; b1_ff <= b1_in;
      whi_ff <= whi_in; st_ff <= st_in; txi_ff <= txi_in; endchk_ff <= endchk_in;
      rd_pend_ff <= rd_pend_in; out_ff <= out_in;
   end

   `MRM_ASSERT_IMP(a_fail_sat, clock, reset, 1'b1, fail_ff <= 4'(FailLimit))
   `MRM_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, rx_cnt_ff <= exp_ff || !active_ff)
   `MRM_ASSERT_NXT(a_link_ok, clock, reset,
      ov_ff && rsp_tready && out_ff.kind == mrm_pkg::KIND_STATUS
      && out_ff.status == mrm_pkg::ST_OK, link_ff)
endmodule
